@@ rtl/sfr_pkg.sv @@
// Shared constants for the serial frame receiver.
// Holds frame limits, field widths and result status codes.
// No dependencies.
package sfr_pkg;

    localparam int MAX_FRAME = 32;
    localparam int POS_W     = $clog2(MAX_FRAME);

    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int OUT_IDX_W = 5;

    // A length byte must stay below this so that the whole frame fits the frame memory.
    localparam int LEN_LIMIT = MAX_FRAME - 3;

    localparam logic [STATUS_W-1:0] ST_FRAME_BYTE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CHK_ERROR  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN    = 2'd3;

    localparam logic OP_RX_BYTE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

endpackage

@@ rtl/sfr_ram.sv @@
// Generic single-write, single-read synchronous RAM.
// Read data is registered and holds while no read is issued.
// No dependencies.
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/serial_frame_receiver.sv @@
// Serial frame receiver: parses start, destination, source, length, data, checksum.
//
// Input channel (in_valid / in_stall): one beat carries op and rx_byte. op selects a
// received byte or a release of the held message. The parser keeps phase, position,
// running sum and length in registers and writes each frame byte into a 32-entry
// frame memory.
// Output channel (out_valid / out_stall): one beat per result. Status results (bad
// length, checksum error, dropped because held) appear in the cycle after the byte
// that causes them. A good frame is read back from the frame memory one byte per
// cycle while the output does not stall, through its registered read port and then
// the output register; the frame has length+3 bytes, and in_stall is high until
// the last byte is loaded into the output register.
// A stall on the output holds the output register; in_stall then rises for any new
// beat, and a readout pauses with its pending memory read held.
// Configuration (cfg_valid / cfg_ready): writes start_byte, always ready.
// Reset clears the parser to hunting, clears the held mark and sets start_byte to 2.
// The frame memory is not cleared; only bytes of the current frame are ever read.
module serial_frame_receiver (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [sfr_pkg::BYTE_W-1:0]       rx_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [sfr_pkg::STATUS_W-1:0]     status,
    output logic [sfr_pkg::BYTE_W-1:0]       out_byte,
    output logic [sfr_pkg::OUT_IDX_W-1:0]    out_index,
    output logic                             last
);
    import sfr_pkg::*;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_DEST = 3'd1;
    localparam logic [2:0] PH_SRC  = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CHK  = 3'd5;

    logic [2:0]          phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    logic [POS_W-1:0]    len_reg, len_next;
    logic                held_reg, held_next;
    logic [BYTE_W-1:0]   start_byte_reg;

    logic                dump_reg, dump_next;
    logic                issued_all_reg, issued_all_next;
    logic [POS_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [POS_W-1:0]    last_idx_reg, last_idx_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [POS_W-1:0]    pend_idx_reg, pend_idx_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [OUT_IDX_W-1:0] out_index_reg, out_index_next;
    logic                last_reg, last_next;

    logic                in_accept;
    logic                out_free;
    logic                load_out;
    logic                issue;
    logic                ram_we;
    logic [BYTE_W-1:0]   ram_rdata;
    logic                status_fire;
    logic [STATUS_W-1:0] status_code;
    logic [POS_W:0]      data_end;
    logic [BYTE_W-1:0]   rx_sum;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = dump_reg || !out_free;
    assign in_accept = in_valid && !in_stall;

    assign rx_sum   = sum_reg + rx_byte;
    assign data_end = {1'b0, len_reg} + (POS_W+1)'(2);

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        len_next        = len_reg;
        held_next       = held_reg;
        dump_next       = dump_reg;
        issued_all_next = issued_all_reg;
        rd_idx_next     = rd_idx_reg;
        last_idx_next   = last_idx_reg;
        ram_we          = 1'b0;
        status_fire     = 1'b0;
        status_code     = ST_BAD_LEN;

        if (in_accept && op == OP_RELEASE)
        begin
            held_next = 1'b0;
        end
        else if (in_accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == start_byte_reg)
                    begin
                        pos_next   = '0;
                        sum_next   = '0;
                        phase_next = PH_DEST;
                    end
                end
                PH_DEST, PH_SRC:
                begin
                    ram_we     = 1'b1;
                    sum_next   = rx_sum;
                    pos_next   = pos_reg + 1'b1;
                    phase_next = (phase_reg == PH_DEST) ? PH_SRC : PH_LEN;
                end
                PH_LEN:
                begin
                    if (rx_byte != '0 && rx_byte < BYTE_W'(LEN_LIMIT))
                    begin
                        ram_we     = 1'b1;
                        sum_next   = rx_sum;
                        len_next   = rx_byte[POS_W-1:0];
                        pos_next   = pos_reg + 1'b1;
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next  = PH_HUNT;
                        status_fire = 1'b1;
                        status_code = ST_BAD_LEN;
                    end
                end
                PH_DATA:
                begin
                    ram_we   = 1'b1;
                    sum_next = rx_sum;
                    if ({1'b0, pos_reg} == data_end)
                    begin
                        phase_next = PH_CHK;
                    end
                    else if (pos_reg < POS_W'(MAX_FRAME - 1))
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                PH_CHK:
                begin
                    phase_next = PH_HUNT;
                    if (sum_reg != rx_byte)
                    begin
                        status_fire = 1'b1;
                        status_code = ST_CHK_ERROR;
                    end
                    else if (held_reg)
                    begin
                        status_fire = 1'b1;
                        status_code = ST_DROPPED;
                    end
                    else
                    begin
                        // Good frame: start reading it back from the frame memory.
                        held_next       = 1'b1;
                        dump_next       = 1'b1;
                        issued_all_next = 1'b0;
                        rd_idx_next     = '0;
                        last_idx_next   = data_end[POS_W-1:0];
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        // Readout: a read is issued when the output register will take its data in
        // time, so one frame byte moves per cycle unless the output stalls.
        load_out      = rd_pend_reg && out_free;
        issue         = dump_reg && !issued_all_reg && (!rd_pend_reg || load_out);
        rd_pend_next  = issue ? 1'b1 : (load_out ? 1'b0 : rd_pend_reg);
        pend_idx_next = issue ? rd_idx_reg : pend_idx_reg;
        if (issue)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
            if (rd_idx_reg == last_idx_reg)
            begin
                issued_all_next = 1'b1;
            end
        end
        if (load_out && pend_idx_reg == last_idx_reg)
        begin
            dump_next = 1'b0;
        end

        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        out_byte_next  = out_byte_reg;
        out_index_next = out_index_reg;
        last_next      = last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_FRAME_BYTE;
            out_byte_next  = ram_rdata;
            out_index_next = OUT_IDX_W'(pend_idx_reg);
            last_next      = (pend_idx_reg == last_idx_reg);
        end
        else if (status_fire)
        begin
            out_valid_next = 1'b1;
            status_next    = status_code;
            out_byte_next  = '0;
            out_index_next = '0;
            last_next      = 1'b1;
        end
    end

    sfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (rx_byte),
        .re    (issue),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            pos_reg        <= '0;
            sum_reg        <= '0;
            held_reg       <= 1'b0;
            start_byte_reg <= BYTE_W'(2);
            dump_reg       <= 1'b0;
            issued_all_reg <= 1'b1;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            held_reg       <= held_next;
            dump_reg       <= dump_next;
            issued_all_reg <= issued_all_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                start_byte_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        rd_idx_reg    <= rd_idx_next;
        last_idx_reg  <= last_idx_next;
        pend_idx_reg  <= pend_idx_next;
        status_reg    <= status_next;
        out_byte_reg  <= out_byte_next;
        out_index_reg <= out_index_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_byte  = out_byte_reg;
    assign out_index = out_index_reg;
    assign last      = last_reg;

endmodule
